/* hdl/bmpru_pkg.sv */
package bmpru_pkg;

	typedef logic [7:0] color_t;

	typedef enum logic [1:0] {
		FMT_1BPP  = 2'd0,
		FMT_4BPP  = 2'd1,
		FMT_8BPP  = 2'd2,
		FMT_24BPP = 2'd3
	} pix_fmt_t;

	// input item kinds
	localparam logic MODE_PALETTE = 1'b0;
	localparam logic MODE_PIXEL   = 1'b1;

	// register word index (paddr[2])
	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_WIDTH  = 1'b1;

	localparam int unsigned CFG_AW = 3;
	localparam int unsigned WIDTH_W = 13;
	localparam int unsigned RGB_W = 24;

	// one decoded pixel as it waits in the output queue
	typedef struct packed {
		color_t red;
		color_t green;
		color_t blue;
		logic   row_end;
		logic   last;
	} pixel_t;

endpackage

/* hdl/bmpru_if.sv */
interface bmpru_item_if import bmpru_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   mode;
	color_t data_byte;
	color_t palette_slot;
	color_t palette_red;
	color_t palette_green;
	color_t palette_blue;

	modport source (
		output valid, mode, data_byte, palette_slot, palette_red, palette_green, palette_blue,
		input  ready
	);
	modport sink (
		input  valid, mode, data_byte, palette_slot, palette_red, palette_green, palette_blue,
		output ready
	);
endinterface

interface bmpru_pixel_if import bmpru_pkg::*; ();
	logic   valid;
	logic   ready;
	color_t red;
	color_t green;
	color_t blue;
	logic   row_end;
	logic   last;

	modport source (
		output valid, red, green, blue, row_end, last,
		input  ready
	);
	modport sink (
		input  valid, red, green, blue, row_end, last,
		output ready
	);
endinterface

/* hdl/bmpru_ram.sv */
module bmpru_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/bmp_pixel_row_unpacker_core.sv */
// Bitmap pixel-array unpacker. Each beat on item either loads one palette entry
// (mode 0) or carries one stored pixel-array byte (mode 1); pixel beats come out on
// pixel in stored row order with row_end on the last pixel of a row and last on the
// final pixel caused by an input byte. Formats 1, 4 and 8 bpp split the byte MSB
// first into palette indices; indices past the row width are dropped, and an index
// at or above PALETTE_DEPTH gives black. In 24 bpp, bytes B, G, R form one pixel.
// Row pad bytes up to the four-byte boundary are swallowed without output.
// Rate: one pixel per cycle while the output queue has room, set by the single
// read port of the palette RAM. A byte gives one index in 8 bpp, two in 4 bpp and
// up to eight in 1 bpp (fewer at a row end); palette loads and pad bytes give none.
// A pixel passes the byte register, palette read and two-deep output queue; steps
// that emit wait while the queue and palette read stage together hold two pixels.
// Palette entries that were never loaded read back undefined. Configure over APB
// (pixel_format at 0x0, image_width at 0x4) only while the block is idle.
module bmp_pixel_row_unpacker_core import bmpru_pkg::*; #(
	parameter int unsigned MAX_WIDTH     = 4096,
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	bmpru_item_if.sink          item,
	bmpru_pixel_if.source       pixel,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column
	localparam int unsigned EW = $clog2(MAX_WIDTH + 1);                     // eff width
	localparam int unsigned AW = $clog2(PALETTE_DEPTH);

	// ---------------- configuration ----------------
	pix_fmt_t             pixel_format_q;
	logic [WIDTH_W-1:0]   image_width_q;
	logic                 cfg_wr;
	logic                 reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_24BPP;
			image_width_q  <= WIDTH_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FORMAT: pixel_format_q <= pix_fmt_t'(pwdata[1:0]);
				REG_WIDTH:  image_width_q  <= pwdata[WIDTH_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FORMAT: prdata = 32'(pixel_format_q);
			REG_WIDTH:  prdata = 32'(image_width_q);
		endcase
	end

	// effective width: zero acts as one, clamp at MAX_WIDTH
	logic [EW-1:0] eff_w;
	logic [4:0]    w5;

	always_comb begin
		if (image_width_q == '0) begin
			eff_w = EW'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(image_width_q);
		end
	end

	assign w5 = 5'(eff_w);  // pad depends on width mod 32 only

	// pad bytes after a row: (-row_bytes) mod 4
	logic [4:0] w_plus7;
	logic [4:0] w_plus1;
	logic [1:0] row_pad;

	assign w_plus7 = w5 + 5'd7;
	assign w_plus1 = w5 + 5'd1;

	always_comb begin
		case (pixel_format_q)
			FMT_1BPP: row_pad = 2'd0 - w_plus7[4:3];
			FMT_4BPP: row_pad = 2'd0 - w_plus1[2:1];
			FMT_8BPP: row_pad = 2'd0 - w5[1:0];
			default:  row_pad = w5[1:0];  // 3*w mod 4 == -w mod 4
		endcase
	end

	// ---------------- current item register ----------------
	logic            busy_q;
	logic [2:0]      k_q;        // index position within the byte
	logic            mode_q;
	color_t          byte_q;
	color_t          slot_q;
	logic [RGB_W-1:0] pal_rgb_q;

	// row / triplet state
	logic [CW-1:0]   column_q;
	logic [1:0]      pad_q;
	logic [1:0]      phase_q;
	color_t          held_blue_q;
	color_t          held_green_q;

	// palette read stage
	logic             valid_s1;
	logic             row_end_s1;
	logic             last_s1;
	logic             direct_s1;
	logic [RGB_W-1:0] rgb_s1;

	// output queue
	pixel_t     fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	logic        is_pix, tri_fmt, emit, pal_emit, col_end, last_k, step, done;
	logic        space, pop, slot_ok, idx_black, item_fire;
	logic [1:0]  phase_eff;
	logic [2:0]  occ;
	color_t      idx;
	logic [RGB_W-1:0] ram_rdata;

	assign pop       = pixel.valid && pixel.ready;
	assign occ       = 3'(count_q) + 3'(valid_s1) - 3'(pop);
	assign space     = occ < 3'd2;

	assign is_pix    = (mode_q == MODE_PIXEL);
	assign tri_fmt   = (pixel_format_q == FMT_24BPP);
	assign phase_eff = (phase_q == 2'd3) ? 2'd0 : phase_q;
	assign emit      = is_pix && (pad_q == 2'd0) && (!tri_fmt || phase_eff == 2'd2);
	assign pal_emit  = emit && !tri_fmt;
	assign col_end   = (EW'(column_q) + EW'(1)) >= eff_w;

	always_comb begin
		case (pixel_format_q)
			FMT_1BPP: begin
				idx    = color_t'(byte_q[3'd7 - k_q]);
				last_k = (k_q == 3'd7);
			end
			FMT_4BPP: begin
				idx    = (k_q == 3'd0) ? color_t'(byte_q[7:4]) : color_t'(byte_q[3:0]);
				last_k = (k_q == 3'd1);
			end
			default: begin
				idx    = byte_q;
				last_k = 1'b1;
			end
		endcase
	end

	assign slot_ok   = {1'b0, slot_q} < 9'(PALETTE_DEPTH);
	assign idx_black = {1'b0, idx} >= 9'(PALETTE_DEPTH);

	// a step that emits needs room downstream; others always go
	assign step      = busy_q && (!emit || space);
	assign done      = step && (!pal_emit || col_end || last_k);
	assign item.ready = !busy_q || done;
	assign item_fire = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			k_q          <= '0;
			column_q     <= '0;
			pad_q        <= '0;
			phase_q      <= '0;
			held_blue_q  <= '0;
			held_green_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= step && emit;
			if (item_fire) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (step) begin
				k_q    <= k_q + 3'd1;
			end

			if (step && is_pix) begin
				if (pad_q != 2'd0) begin
					pad_q <= pad_q - 2'd1;
				end else begin
					if (tri_fmt) begin
						case (phase_eff)
							2'd0: begin
								held_blue_q <= byte_q;
								phase_q     <= 2'd1;
							end
							2'd1: begin
								held_green_q <= byte_q;
								phase_q      <= 2'd2;
							end
							default: phase_q <= 2'd0;
						endcase
					end
					if (emit) begin
						if (col_end) begin
							column_q <= '0;
							pad_q    <= row_pad;
						end else begin
							column_q <= column_q + CW'(1);
						end
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_fire) begin
			mode_q    <= item.mode;
			byte_q    <= item.data_byte;
			slot_q    <= item.palette_slot;
			pal_rgb_q <= {item.palette_red, item.palette_green, item.palette_blue};
		end
		row_end_s1 <= col_end;
		last_s1    <= tri_fmt || col_end || last_k;
		direct_s1  <= tri_fmt || idx_black;
		rgb_s1     <= tri_fmt ? {byte_q, held_green_q, held_blue_q} : '0;
	end

	// palette store: written by mode 0 items in order with lookups
	bmpru_ram #(
		.WIDTH (RGB_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (step && !is_pix && slot_ok),
		.waddr (AW'(slot_q)),
		.wdata (pal_rgb_q),
		.raddr (AW'(idx)),
		.rdata (ram_rdata)
	);

	// ---------------- output queue ----------------
	pixel_t           push_px;
	logic [RGB_W-1:0] push_rgb;

	assign push_rgb = direct_s1 ? rgb_s1 : ram_rdata;
	assign push_px  = '{red: push_rgb[23:16], green: push_rgb[15:8], blue: push_rgb[7:0],
	                    row_end: row_end_s1, last: last_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(valid_s1) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fifo_q[wr_ptr_q] <= push_px;
		end
	end

	assign pixel.valid   = (count_q != 2'd0);
	assign pixel.red     = fifo_q[rd_ptr_q].red;
	assign pixel.green   = fifo_q[rd_ptr_q].green;
	assign pixel.blue    = fifo_q[rd_ptr_q].blue;
	assign pixel.row_end = fifo_q[rd_ptr_q].row_end;
	assign pixel.last    = fifo_q[rd_ptr_q].last;

	// ---------------- checks ----------------
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(count_q == 2'd2 && valid_s1))
		else $error("output queue overflow");

	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(column_q) < 32'(MAX_WIDTH))
		else $error("column beyond max width");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("bad triplet phase");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && row_end_s1 |-> column_q == '0)
		else $error("row end without column wrap");

	a_pad_after_row: assert property (@(posedge clk) disable iff (!arst_n)
		$past(pad_q) == 2'd0 && pad_q != 2'd0 |-> valid_s1 && row_end_s1)
		else $error("pad count loaded outside a row end");

endmodule

/* sim/bmpru_pixel_checker.sv */
`timescale 1ns / 1ps

module bmpru_pixel_checker import bmpru_pkg::*; #(
	parameter int unsigned MAX_WIDTH     = 4096,
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	bmpru_item_if             item,
	bmpru_pixel_if            pixel,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending,
	output int                pixels_checked,
	output int                rows_closed,
	output int                pads_dropped
);
	pix_fmt_t           fmt;
	logic [WIDTH_W-1:0] width_reg;
	logic [RGB_W-1:0]   palette [PALETTE_DEPTH];
	int                 column;
	logic [1:0]         pad_left;
	logic [1:0]         triplet_pos;
	color_t             held_blue;
	color_t             held_green;
	pixel_t             pixels_due [$];

	function automatic int row_width();
		int w;
		w = int'(width_reg);
		if (w == 0) w = 1;
		if (w > int'(MAX_WIDTH)) w = int'(MAX_WIDTH);
		return w;
	endfunction

	// pad bytes after a row, for the format in force when the row closes
	function automatic logic [1:0] row_pad(int w);
		int nbytes;
		case (fmt)
			FMT_1BPP: nbytes = (w + 7) >> 3;
			FMT_4BPP: nbytes = (w + 1) >> 1;
			FMT_8BPP: nbytes = w;
			default:  nbytes = w * 3;
		endcase
		return 2'((4 - (nbytes & 3)) & 3);
	endfunction

	function automatic logic step_column(int w);
		if (column + 1 >= w) begin
			column = 0;
			pad_left = row_pad(w);
			return 1'b1;
		end
		column = column + 1;
		return 1'b0;
	endfunction

	// expected pixels for one accepted item beat
	task automatic decode_beat();
		int               w;
		int               per;
		int               k;
		int               idx;
		logic [RGB_W-1:0] ent;
		pixel_t           px;
		w = row_width();
		if (item.mode == MODE_PALETTE) begin
			if (int'(item.palette_slot) < int'(PALETTE_DEPTH))
				palette[item.palette_slot] = {item.palette_red, item.palette_green,
					item.palette_blue};
			return;
		end
		if (pad_left != 2'd0) begin
			pad_left = pad_left - 2'd1;
			pads_dropped++;
			return;
		end
		if (fmt == FMT_24BPP) begin
			case (triplet_pos)
				2'd1: begin
					held_green = item.data_byte;
					triplet_pos = 2'd2;
				end
				2'd2: begin
					triplet_pos = 2'd0;
					px.red = item.data_byte;
					px.green = held_green;
					px.blue = held_blue;
					px.row_end = step_column(w);
					px.last = 1'b1;
					pixels_due = {pixels_due, px};
				end
				default: begin
					held_blue = item.data_byte;
					triplet_pos = 2'd1;
				end
			endcase
			return;
		end
		per = (fmt == FMT_1BPP) ? 8 : (fmt == FMT_4BPP) ? 2 : 1;
		for (k = 0; k < per; k++) begin
			case (fmt)
				FMT_1BPP: idx = int'(item.data_byte[7 - k]);
				FMT_4BPP: idx = (k == 0) ? int'(item.data_byte[7:4])
					: int'(item.data_byte[3:0]);
				default:  idx = int'(item.data_byte);
			endcase
			ent = (idx < int'(PALETTE_DEPTH)) ? palette[idx] : '0;
			px.red = ent[23:16];
			px.green = ent[15:8];
			px.blue = ent[7:0];
			px.row_end = step_column(w);
			px.last = px.row_end || (k == per - 1);
			pixels_due = {pixels_due, px};
			if (px.row_end) break;
		end
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (pixels_due.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("pixel with none due: r=%02h g=%02h b=%02h row_end=%b last=%b",
					pixel.red, pixel.green, pixel.blue, pixel.row_end, pixel.last);
			return;
		end
		want = pixels_due.pop_front();
		pixels_checked++;
		if (pixel.row_end === 1'b1) rows_closed++;
		if (pixel.red !== want.red || pixel.green !== want.green ||
				pixel.blue !== want.blue || pixel.row_end !== want.row_end ||
				pixel.last !== want.last) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("pixel %0d mismatch: want r=%02h g=%02h b=%02h row_end=%b last=%b",
					pixels_checked, want.red, want.green, want.blue, want.row_end,
					want.last);
				$display("  got r=%02h g=%02h b=%02h row_end=%b last=%b",
					pixel.red, pixel.green, pixel.blue, pixel.row_end, pixel.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt = FMT_24BPP;
			width_reg = WIDTH_W'(1);
			for (int i = 0; i < int'(PALETTE_DEPTH); i++) palette[i] = '0;
			column = 0;
			pad_left = 2'd0;
			triplet_pos = 2'd0;
			held_blue = '0;
			held_green = '0;
			pixels_due.delete();
			fail_count = 0;
			pixels_checked = 0;
			rows_closed = 0;
			pads_dropped = 0;
			pending = 0;
		end else begin
			// older pixels leave before the new beat's pixels are queued
			if (pixel.valid && pixel.ready) check_pixel();
			if (item.valid && item.ready) decode_beat();
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_FORMAT) fmt = pix_fmt_t'(pwdata[1:0]);
				else width_reg = pwdata[WIDTH_W-1:0];
			end
			pending = pixels_due.size();
		end
	end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
	import bmpru_pkg::*;

	localparam int LIMIT_CYCLES    = 200000;
	localparam int QUIET_CYCLES    = 16;   // covers byte reg, palette read, queue, spare
	localparam int HOLD_CYCLES     = 80;
	localparam int PHASE_COUNT     = 9;
	localparam int BEATS_PER_PHASE = 18;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	bmpru_item_if  item_ch ();
	bmpru_pixel_if pixel_ch ();

	int   fail_count;
	int   pending;
	int   pixels_checked;
	int   rows_closed;
	int   pads_dropped;

	// percent of cycles each side sits idle; changed between phases
	int   tx_idle_pct;
	int   rx_idle_pct;
	logic hold_req;
	logic hold_done;

	// palette slots loaded so far; lookups only ever hit these
	logic loaded [256];

	int   beats_sent;
	int   loads_sent;
	int   settings_used;
	int   cycle_count;

	bmp_pixel_row_unpacker_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.pixel   (pixel_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bmpru_pixel_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item_ch),
		.pixel          (pixel_ch),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.fail_count     (fail_count),
		.pending        (pending),
		.pixels_checked (pixels_checked),
		.rows_closed    (rows_closed),
		.pads_dropped   (pads_dropped)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Pixel receiver: random ready at the current idle rate. Once, on request,
	// it holds ready low for a long stretch so the output queue and pipe fill
	// up and the block pushes back on item.
	initial begin : pixel_receiver
		hold_done = 1'b0;
		pixel_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				pixel_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pixel_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// hard stop for a hung block
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: errors");
		$finish;
	end

	// One item beat. Returns at the edge where it was taken; valid stays up so
	// a following beat can go out back to back.
	task automatic send_beat(input logic mode, input color_t data, input color_t slot,
			input color_t r, input color_t g, input color_t b);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode <= mode;
		item_ch.data_byte <= data;
		item_ch.palette_slot <= slot;
		item_ch.palette_red <= r;
		item_ch.palette_green <= g;
		item_ch.palette_blue <= b;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		beats_sent++;
		if (mode == MODE_PALETTE) begin
			loaded[slot] = 1'b1;
			loads_sent++;
		end
	endtask

	task automatic load_slot(input color_t slot);
		send_beat(MODE_PALETTE, color_t'($urandom_range(255)), slot,
			color_t'($urandom_range(255)), color_t'($urandom_range(255)),
			color_t'($urandom_range(255)));
	endtask

	task automatic pixel_byte(input color_t data);
		send_beat(MODE_PIXEL, data, color_t'($urandom_range(255)),
			color_t'($urandom_range(255)), color_t'($urandom_range(255)),
			color_t'($urandom_range(255)));
	endtask

	// Stop offering, wait for every due pixel, then give trailing pad or
	// palette beats time to pass through before touching registers.
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// APB write: setup, then access; pready is tied high in the block
	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Register settings per phase: both width extremes (0 acts as 1, 8191
	// clamps to the max), exactly the max, and small widths so rows close and
	// pad bytes come often.
	function automatic void phase_setting(input int ph, output pix_fmt_t f,
			output logic [WIDTH_W-1:0] w);
		case (ph)
			0: begin f = FMT_1BPP;  w = WIDTH_W'(10);   end
			1: begin f = FMT_4BPP;  w = WIDTH_W'($urandom_range(13, 1)); end
			2: begin f = FMT_8BPP;  w = WIDTH_W'(1);    end
			3: begin f = FMT_24BPP; w = WIDTH_W'(0);    end
			4: begin f = FMT_1BPP;  w = WIDTH_W'(8191); end
			5: begin f = FMT_8BPP;  w = WIDTH_W'($urandom_range(13, 1)); end
			6: begin f = FMT_4BPP;  w = WIDTH_W'(4096); end
			7: begin f = FMT_24BPP; w = WIDTH_W'($urandom_range(13, 1)); end
			default: begin f = FMT_1BPP; w = WIDTH_W'($urandom_range(20, 1)); end
		endcase
	endfunction

	initial begin : stimulus
		pix_fmt_t           cur_fmt;
		logic [WIDTH_W-1:0] cur_width;
		color_t             pick;
		int                 i;
		int                 ph;
		int                 n;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.mode <= MODE_PIXEL;
		item_ch.data_byte <= '0;
		item_ch.palette_slot <= '0;
		item_ch.palette_red <= '0;
		item_ch.palette_green <= '0;
		item_ch.palette_blue <= '0;
		tx_idle_pct = 34;
		rx_idle_pct = 56;
		hold_req = 1'b0;
		beats_sent = 0;
		loads_sent = 0;
		settings_used = 1;   // reset setting counts as one
		for (i = 0; i < 256; i++) loaded[i] = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// Palette: all-zero and all-one colors in the two 1 bpp slots, the
		// rest of the 4 bpp range random, plus the top slot.
		send_beat(MODE_PALETTE, 8'h00, 8'd0, 8'h00, 8'h00, 8'h00);
		send_beat(MODE_PALETTE, 8'hff, 8'd1, 8'hff, 8'hff, 8'hff);
		for (i = 2; i < 16; i++) load_slot(color_t'(i));
		send_beat(MODE_PALETTE, 8'h5a, 8'd255, 8'h80, 8'h01, 8'h7f);

		// Reset setting is 24 bpp, one pixel per row: B,G,R then one pad byte.
		// First two bytes of each triplet give nothing.
		pixel_byte(8'h00);
		pixel_byte(8'hff);
		pixel_byte(8'h80);
		pixel_byte(8'hff);   // pad, dropped
		pixel_byte(8'hff);
		pixel_byte(8'h00);
		pixel_byte(8'h7f);
		pixel_byte(8'h00);   // pad, dropped

		// --- random phases ---
		// Register writes land between phases with the row position left
		// wherever the last phase stopped, so rows change format mid-way.
		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			drain();
			if (ph < 3) begin
				tx_idle_pct = 34;
				rx_idle_pct = 56;
			end else if (ph < 6) begin
				tx_idle_pct = 56;
				rx_idle_pct = 34;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			phase_setting(ph, cur_fmt, cur_width);
			write_reg(REG_FORMAT, 32'(cur_fmt));
			write_reg(REG_WIDTH, 32'(cur_width));
			settings_used++;
			// long receiver stall while bytes keep coming at full rate
			if (ph == 6) hold_req = 1'b1;

			for (n = 0; n < BEATS_PER_PHASE; n++) begin
				pick = color_t'($urandom_range(255));
				if ($urandom_range(9) == 0) begin
					load_slot(pick);
				end else begin
					// 8 bpp looks the byte up directly; load it first if new
					if (cur_fmt == FMT_8BPP && !loaded[pick]) load_slot(pick);
					pixel_byte(pick);
				end
			end
		end

		drain();
		$display("tb: %0d item beats (%0d palette loads) over %0d register settings",
			beats_sent, loads_sent, settings_used);
		$display("tb: %0d pixels compared, %0d row ends, %0d pad bytes skipped",
			pixels_checked, rows_closed, pads_dropped);
		if (fail_count == 0 && pending == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end

endmodule
